@@ rtl/core/md4_pkg.sv @@
`timescale 1ns / 1ps

package md4_pkg;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam logic [31:0] K1 = 32'h5A827999;
  localparam logic [31:0] K2 = 32'h6ED9EBA1;
  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned NumSteps = 48;

  typedef logic [3:0][31:0] chain_t;

  typedef struct packed {
    logic start;
    logic init;
  } md4_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md4_stat_t;

  // Message word used by a step: in order, then column order, then bit-reversed order.
  function automatic logic [3:0] word_order(input logic [5:0] step);
    logic [3:0] j;
    logic [3:0] idx;
    begin
      j = step[3:0];
      case (step[5:4])
        2'd0: idx = j;
        2'd1: idx = {j[1:0], j[3:2]};
        2'd2: idx = {j[0], j[1], j[2], j[3]};
        default: idx = 4'd0;
      endcase
      return idx;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [1:0] round, input logic [1:0] lane);
    logic [4:0] s;
    begin
      case ({round, lane})
        4'h0: s = 5'd3;
        4'h1: s = 5'd7;
        4'h2: s = 5'd11;
        4'h3: s = 5'd19;
        4'h4: s = 5'd3;
        4'h5: s = 5'd5;
        4'h6: s = 5'd9;
        4'h7: s = 5'd13;
        4'h8: s = 5'd3;
        4'h9: s = 5'd9;
        4'hA: s = 5'd11;
        4'hB: s = 5'd15;
        default: s = 5'd1;
      endcase
      return s;
    end
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

@@ rtl/core/md4_if.sv @@
`timescale 1ns / 1ps

interface md4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output msg_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink (input valid, input msg_byte, input has_byte, input end_of_message,
                output ready);
endinterface

interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

@@ rtl/core/md4_buf.sv @@
`timescale 1ns / 1ps

module md4_buf (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [31:0] wdata_i,
  input  logic [3:0]  raddr_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem_q [16];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/md4_round.sv @@
`timescale 1ns / 1ps

module md4_round import md4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  md4_ctl_t    ctl_i,
  input  logic [31:0] rdata_i,
  output logic [3:0]  raddr_o,
  output md4_stat_t   stat_o,
  output chain_t      chain_o
);

  logic        busy_q;
  logic [5:0]  iss_q;
  chain_t      chain_q;
  logic [31:0] wa_q, wb_q, wc_q, wd_q;

  logic [5:0]  step;
  logic [31:0] f, k, sum, rot;
  logic        last_step;

  // Reads run one step ahead of the datapath to cover the memory latency.
  assign raddr_o   = word_order(iss_q);
  assign step      = iss_q - 6'd1;
  assign last_step = busy_q && (iss_q == 6'(NumSteps));

  always_comb begin
    case (step[5:4])
      2'd0: begin
        f = wd_q ^ (wb_q & (wc_q ^ wd_q));
        k = '0;
      end
      2'd1: begin
        f = (wb_q & wc_q) | (wb_q & wd_q) | (wc_q & wd_q);
        k = K1;
      end
      2'd2: begin
        f = wb_q ^ wc_q ^ wd_q;
        k = K2;
      end
      default: begin
        f = '0;
        k = '0;
      end
    endcase
    sum = wa_q + f + rdata_i + k;
    rot = rotl32(sum, rot_amount(step[5:4], step[1:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      iss_q   <= '0;
      chain_q <= {IvD, IvC, IvB, IvA};
      wa_q    <= '0;
      wb_q    <= '0;
      wc_q    <= '0;
      wd_q    <= '0;
    end else begin
      if (ctl_i.init) begin
        chain_q <= {IvD, IvC, IvB, IvA};
      end
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        iss_q  <= '0;
        wa_q   <= chain_q[0];
        wb_q   <= chain_q[1];
        wc_q   <= chain_q[2];
        wd_q   <= chain_q[3];
      end else if (busy_q) begin
        iss_q <= iss_q + 6'd1;
        if (iss_q != '0) begin
          wa_q <= wd_q;
          wb_q <= rot;
          wc_q <= wb_q;
          wd_q <= wc_q;
        end
        if (last_step) begin
          busy_q     <= 1'b0;
          chain_q[0] <= chain_q[0] + wd_q;
          chain_q[1] <= chain_q[1] + rot;
          chain_q[2] <= chain_q[2] + wb_q;
          chain_q[3] <= chain_q[3] + wc_q;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = last_step;
  assign chain_o     = chain_q;

endmodule

@@ rtl/core/md4_message_digest_unit.sv @@
`timescale 1ns / 1ps

// MD4 digest engine for a byte stream.
// The input channel takes one word per item: a message byte with its has_byte
// flag and an end_of_message flag. A word with has_byte low only ends the
// message, or does nothing when end_of_message is low as well.
// Message bytes are packed into 32-bit words in a 16-entry block memory. Input
// is taken one word per cycle while no block is in work. The word that fills a
// 64-byte block starts the compression, which holds off input until it is done,
// one step per cycle with the memory read for each step issued ahead of it.
// At message end the padding sequencer writes one memory word per cycle (a setup
// state, then up to 16 writes), then compresses, and does so twice when
// the length no longer fits the last block.
// The output channel then carries the four digest words a, b, c, d, one per
// cycle while the receiver is ready. A stalled receiver holds the current word
// and input stays blocked until d is taken; the engine then reloads its
// initial values and takes the next message.
// Reset loads the initial chaining values and clears the byte count; the
// block accepts input as soon as reset is released.
module md4_message_digest_unit import md4_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  md4_in_if.sink in_i,
  md4_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_PREP,
    S_PAD,
    S_OUT
  } state_e;

  state_e      state_q;
  logic [60:0] cnt_q;
  logic [31:0] word_q;
  logic [3:0]  pidx_q;
  logic        two_q;
  logic        second_q;
  logic        fin_q;
  logic        pend_q;
  logic        pad_q;
  logic [1:0]  oidx_q;

  md4_ctl_t    ctl;
  md4_stat_t   stat;
  chain_t      chain;
  logic [3:0]  raddr;
  logic [31:0] rdata;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [31:0] pad_word;
  logic [31:0] pad_data;
  logic [63:0] bit_len;
  logic [5:0]  pos;
  logic        in_acc;
  logic        out_acc;
  logic        len_blk;
  logic        byte_acc;

  assign pos      = cnt_q[5:0];
  assign bit_len  = {cnt_q, 3'b000};
  assign len_blk  = !two_q || second_q;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign byte_acc = in_acc && in_i.has_byte;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (2'(l) < pos[1:0]) begin
        pad_word[8*l +: 8] = word_q[8*l +: 8];
      end else if (2'(l) == pos[1:0]) begin
        pad_word[8*l +: 8] = PadByte;
      end else begin
        pad_word[8*l +: 8] = '0;
      end
    end
    if (!second_q && (pidx_q == pos[5:2])) begin
      pad_data = pad_word;
    end else if (len_blk && (pidx_q == 4'd14)) begin
      pad_data = bit_len[31:0];
    end else if (len_blk && (pidx_q == 4'd15)) begin
      pad_data = bit_len[63:32];
    end else begin
      pad_data = '0;
    end
  end

  assign mem_we    = (byte_acc && (pos[1:0] == 2'd3)) || (state_q == S_PAD);
  assign mem_waddr = (state_q == S_PAD) ? pidx_q : pos[5:2];
  assign mem_wdata = (state_q == S_PAD) ? pad_data : {in_i.msg_byte, word_q[23:0]};

  assign ctl.start = (byte_acc && (pos == 6'd63)) ||
                     ((state_q == S_PAD) && (pidx_q == 4'd15));
  assign ctl.init  = out_acc && (oidx_q == 2'd3);

  md4_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  md4_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .rdata_i (rdata),
    .raddr_o (raddr),
    .stat_o  (stat),
    .chain_o (chain)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      word_q   <= '0;
      pidx_q   <= '0;
      two_q    <= 1'b0;
      second_q <= 1'b0;
      fin_q    <= 1'b0;
      pend_q   <= 1'b0;
      pad_q    <= 1'b0;
      oidx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.has_byte) begin
              word_q[8*pos[1:0] +: 8] <= in_i.msg_byte;
              cnt_q <= cnt_q + 61'd1;
            end
            if (byte_acc && (pos == 6'd63)) begin
              pend_q  <= in_i.end_of_message;
              state_q <= S_COMP;
            end else if (in_i.end_of_message) begin
              state_q <= S_PREP;
            end
          end
        end
        S_COMP: begin
          if (stat.done) begin
            if (fin_q) begin
              oidx_q  <= '0;
              state_q <= S_OUT;
            end else if (pad_q) begin
              second_q <= 1'b1;
              pidx_q   <= '0;
              state_q  <= S_PAD;
            end else if (pend_q) begin
              state_q <= S_PREP;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_PREP: begin
          pidx_q   <= pos[5:2];
          two_q    <= (pos[5:2] >= 4'd14);
          second_q <= 1'b0;
          pad_q    <= 1'b1;
          state_q  <= S_PAD;
        end
        S_PAD: begin
          if (pidx_q == 4'd15) begin
            fin_q   <= len_blk;
            state_q <= S_COMP;
          end else begin
            pidx_q <= pidx_q + 4'd1;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            oidx_q <= oidx_q + 2'd1;
            if (oidx_q == 2'd3) begin
              cnt_q   <= '0;
              fin_q   <= 1'b0;
              pad_q   <= 1'b0;
              pend_q  <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = chain[oidx_q];
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = (oidx_q == 2'd3);

  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !stat.busy)
    else $error("input accepted while a block is compressed");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !mem_we)
    else $error("block memory written during compression");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_word) |=> (cnt_q == '0) && in_i.ready)
    else $error("engine not restarted after the last digest word");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_o.valid && in_i.ready))
    else $error("input open while the digest is delivered");

endmodule
